@@ src/filled_circle_point_generator_assert.svh @@
// assertion macros for the filled circle point generator
// expects clk and rst_n in the scope of use
`ifndef FILLED_CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define FILLED_CIRCLE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define FCPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fcpg_pkg.sv @@
// shared constants and types for the filled circle point generator
// no dependencies
`timescale 1ns / 1ps

package fcpg_pkg;

    localparam int COORD_BITS      = 10;
    localparam int PIX_BITS        = 12;
    localparam int RAD_BITS        = 8;
    localparam int DEC_BITS        = 11;
    localparam int IDX_BITS        = 4;
    localparam int CENTRE_IN_BITS  = 10;
    localparam logic [RAD_BITS-1:0] MAP_RADIUS = RAD_BITS'(32);

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // one octant step worth of points
    typedef struct packed
    {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [RAD_BITS-1:0]   major1;
        logic [RAD_BITS-1:0]   minor1;
        logic [RAD_BITS-1:0]   diag;
        logic                  has_diag;
        logic [RAD_BITS-1:0]   radius;
        logic                  last;
    } job_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } emit_status_t;

endpackage

@@ src/fcpg_emit.sv @@
// point serialiser: expands one octant job into 8 or 16 mirrored pixel words
// depends on fcpg_pkg
`timescale 1ns / 1ps

module fcpg_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_load,
    input  fcpg_pkg::job_t                job,
    output fcpg_pkg::emit_status_t        status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [fcpg_pkg::PIX_BITS-1:0] pixel_x,
    output logic signed [fcpg_pkg::PIX_BITS-1:0] pixel_y,
    output logic [fcpg_pkg::RAD_BITS-1:0] ring_radius,
    output logic                          last_point
);
    import fcpg_pkg::*;

    job_t                job_reg;
    logic                job_valid_reg, job_valid_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIX_BITS-1:0] px_reg, px_next;
    logic [PIX_BITS-1:0] py_reg, py_next;
    logic [RAD_BITS-1:0] rad_reg;
    logic                last_reg, last_next;

    logic                out_load;
    logic                at_end;
    logic [RAD_BITS-1:0] a, b, dx_mag, dy_mag;
    logic                neg_x, neg_y;
    logic [PIX_BITS-1:0] dx, dy;

    always_comb
    begin
        out_load = job_valid_reg && (!out_valid_reg || !out_stall);
        at_end   = job_reg.has_diag ? (idx_reg == {IDX_BITS{1'b1}})
                                    : (idx_reg == IDX_BITS'(7));

        a      = idx_reg[3] ? job_reg.diag : job_reg.major1;
        b      = idx_reg[3] ? job_reg.diag : job_reg.minor1;
        dx_mag = idx_reg[0] ? b : a;
        dy_mag = idx_reg[0] ? a : b;
        neg_x  = idx_reg[2:0] inside {[3'd2:3'd5]};
        neg_y  = idx_reg[2];
        dx     = neg_x ? -PIX_BITS'(dx_mag) : PIX_BITS'(dx_mag);
        dy     = neg_y ? -PIX_BITS'(dy_mag) : PIX_BITS'(dy_mag);
        px_next   = PIX_BITS'(job_reg.cx) + dx;
        py_next   = PIX_BITS'(job_reg.cy) + dy;
        last_next = job_reg.last && at_end;

        status.busy = job_valid_reg;
        status.done = out_load && at_end;

        if (job_load)
            job_valid_next = 1'b1;
        else if (status.done)
            job_valid_next = 1'b0;
        else
            job_valid_next = job_valid_reg;

        if (job_load)
            idx_next = '0;
        else if (out_load)
            idx_next = idx_reg + IDX_BITS'(1);
        else
            idx_next = idx_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
            job_reg <= job;
        if (out_load)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            rad_reg  <= job_reg.radius;
            last_reg <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign ring_radius = rad_reg;
    assign last_point  = last_reg;

endmodule

@@ src/filled_circle_point_generator.sv @@
// filled circle point generator top level: ring stepping state and output serialiser
// depends on fcpg_pkg, fcpg_emit and filled_circle_point_generator_assert.svh
//
// input channel in_valid/in_stall carries operation, center_x, center_y.
// a start word loads the centre and arms the outer ring at max_radius; it
// emits nothing. an advance word on an armed ring takes one octant step and queues 8 points,
// or 16 when the ring's final step lands on the diagonal.
// output channel out_valid/out_stall carries one pixel word per cycle while out_stall is low.
// with the output register free, an accepted advance word is registered into the
// job slot, and its first point then into the output register, where it can be taken.
// throughput: one pixel word per cycle while out_stall is low, set by the
// single-point output register. the next word is accepted in the cycle the
// current job hands over its final point, so jobs follow with no gap. start
// words and advances while idle are accepted whenever the job slot is free.
// max_radius is written through cfg_write_en/cfg_write_data, reset value 32.
// reset clears the ring state and drops any queued points.
// a stall on the output holds the pixel word and, once the job slot is
// full, stalls the input.
`timescale 1ns / 1ps

`include "filled_circle_point_generator_assert.svh"

module filled_circle_point_generator
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic                                        operation,
    input  logic [fcpg_pkg::CENTRE_IN_BITS-1:0]         center_x,
    input  logic [fcpg_pkg::CENTRE_IN_BITS-1:0]         center_y,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [fcpg_pkg::PIX_BITS-1:0]        pixel_x,
    output logic signed [fcpg_pkg::PIX_BITS-1:0]        pixel_y,
    output logic [fcpg_pkg::RAD_BITS-1:0]               ring_radius,
    output logic                                        last_point,
    input  logic                                        cfg_write_en,
    input  logic [fcpg_pkg::RAD_BITS-1:0]               cfg_write_data
);
    import fcpg_pkg::*;

    logic [RAD_BITS-1:0]   max_radius_reg;
    logic                  busy_reg, busy_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [RAD_BITS-1:0]   radius_reg, radius_next;
    logic [RAD_BITS-1:0]   major_reg, major_next;
    logic [RAD_BITS-1:0]   minor_reg, minor_next;
    logic [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [RAD_BITS-1:0]   steps_reg, steps_next;

    logic                  in_accept;
    logic                  job_load;
    job_t                  job;
    emit_status_t          status;
    logic [RAD_BITS-1:0]   st_major, st_minor, st_steps, arm_r;
    logic [DEC_BITS-1:0]   st_dec;
    logic                  ring_end;

    assign in_stall  = status.busy && !status.done;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        busy_next   = busy_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        radius_next = radius_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        dec_next    = dec_reg;
        steps_next  = steps_reg;
        job_load    = 1'b0;

        // octant step
        if (dec_reg[DEC_BITS-1] || dec_reg == '0)
        begin
            st_dec   = dec_reg + DEC_BITS'({minor_reg, 1'b1});
            st_minor = minor_reg + RAD_BITS'(1);
            st_major = major_reg;
        end
        else
        begin
            st_dec   = dec_reg - DEC_BITS'({major_reg, 1'b0}) + DEC_BITS'(1);
            st_minor = minor_reg;
            st_major = major_reg - RAD_BITS'(1);
        end
        st_steps = steps_reg - RAD_BITS'(1);
        ring_end = (st_steps == '0);
        arm_r    = (radius_reg <= RAD_BITS'(1)) ? '0 : radius_reg - RAD_BITS'(1);

        job.cx       = col_reg;
        job.cy       = row_reg;
        job.major1   = major_reg;
        job.minor1   = minor_reg;
        job.diag     = st_major;
        job.has_diag = ring_end && (st_major == st_minor);
        job.radius   = radius_reg;
        job.last     = ring_end && (radius_reg <= RAD_BITS'(1));

        if (in_accept)
        begin
            case (op_t'(operation))
                OP_START:
                begin
                    col_next    = COORD_BITS'(center_x);
                    row_next    = COORD_BITS'(center_y);
                    radius_next = max_radius_reg;
                    major_next  = max_radius_reg;
                    minor_next  = '0;
                    dec_next    = '0;
                    steps_next  = max_radius_reg;
                    busy_next   = (max_radius_reg != '0);
                end
                OP_ADVANCE:
                begin
                    if (busy_reg)
                    begin
                        job_load = 1'b1;
                        if (ring_end)
                        begin
                            radius_next = arm_r;
                            major_next  = arm_r;
                            minor_next  = '0;
                            dec_next    = '0;
                            steps_next  = arm_r;
                            busy_next   = (arm_r != '0);
                        end
                        else
                        begin
                            major_next = st_major;
                            minor_next = st_minor;
                            dec_next   = st_dec;
                            steps_next = st_steps;
                        end
                    end
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_radius_reg <= MAP_RADIUS;
            busy_reg       <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            radius_reg     <= '0;
            major_reg      <= '0;
            minor_reg      <= '0;
            dec_reg        <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            if (cfg_write_en)
                max_radius_reg <= cfg_write_data;
            busy_reg   <= busy_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            radius_reg <= radius_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            dec_reg    <= dec_next;
            steps_reg  <= steps_next;
        end
    end

    fcpg_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (job_load),
        .job         (job),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .ring_radius (ring_radius),
        .last_point  (last_point)
    );

    `FCPG_ASSERT_NOW(a_busy_has_steps, busy_reg, steps_reg != '0, "busy ring with no steps left")
    `FCPG_ASSERT_NOW(a_last_on_unit_ring, out_valid && last_point, ring_radius == RAD_BITS'(1), "last point off the unit ring")
    `FCPG_ASSERT_NEXT(a_advance_queues_job, in_accept && operation && busy_reg, status.busy, "advance did not queue points")

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for filled_circle_point_generator
// predicts every pixel word of each disc ring and compares in order
// depends on fcpg_pkg and the filled_circle_point_generator rtl
`timescale 1ns / 1ps

module tb_top;

    import fcpg_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int MODE_ITEMS   = 95;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic [RAD_BITS-1:0]        ring_radius;
        logic                       last_point;
    } pixel_word_t;

    typedef struct packed
    {
        op_t                       op;
        logic [CENTRE_IN_BITS-1:0] cx;
        logic [CENTRE_IN_BITS-1:0] cy;
    } disc_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic [CENTRE_IN_BITS-1:0] center_x = '0;
    logic [CENTRE_IN_BITS-1:0] center_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic [RAD_BITS-1:0] ring_radius;
    logic last_point;
    logic cfg_write_en = 1'b0;
    logic [RAD_BITS-1:0] cfg_write_data = '0;

    disc_word_t  pending_words[$];
    pixel_word_t expected_pixels[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int words_accepted = 0;
    int pixels_checked = 0;
    int discs_closed = 0;
    int mismatch_count = 0;

    // predictor state
    logic [RAD_BITS-1:0] radius_setting = MAP_RADIUS;
    bit disc_busy = 1'b0;
    int centre_col = 0;
    int centre_row = 0;
    int ring_r = 0;
    int off_major = 0;
    int off_minor = 0;
    int dec_term = 0;
    int steps_remaining = 0;

    filled_circle_point_generator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .center_x       (center_x),
        .center_y       (center_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .ring_radius    (ring_radius),
        .last_point     (last_point),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #CLK_HALF_NS clk = ~clk;

    task automatic arm_ring(input int r);
        ring_r = r & 8'hff;
        off_major = ring_r;
        off_minor = 0;
        dec_term = 0;
        steps_remaining = ring_r;
    endtask

    task automatic push_ring_point(input int dx, input int dy);
        pixel_word_t w;
        int px;
        int py;
        px = centre_col + dx;
        py = centre_row + dy;
        w.pixel_x = px[PIX_BITS-1:0];
        w.pixel_y = py[PIX_BITS-1:0];
        w.ring_radius = ring_r[RAD_BITS-1:0];
        w.last_point = 1'b0;
        expected_pixels.insert(expected_pixels.size(), w);
    endtask

    task automatic push_octants(input int a, input int b);
        push_ring_point(a, b);
        push_ring_point(b, a);
        push_ring_point(-a, b);
        push_ring_point(-b, a);
        push_ring_point(-a, -b);
        push_ring_point(-b, -a);
        push_ring_point(a, -b);
        push_ring_point(b, -a);
    endtask

    task automatic compute_disc_points(input disc_word_t dw);
        pixel_word_t w;
        if (dw.op == OP_START)
        begin
            centre_col = int'(dw.cx) & ((1 << COORD_BITS) - 1);
            centre_row = int'(dw.cy) & ((1 << COORD_BITS) - 1);
            arm_ring(int'(radius_setting));
            disc_busy = (ring_r != 0);
            return;
        end
        if (!disc_busy)
            return;
        push_octants(off_major, off_minor);
        if (dec_term <= 0)
        begin
            dec_term += 2 * off_minor + 1;
            off_minor = (off_minor + 1) & 8'hff;
        end
        else
        begin
            dec_term += 1 - 2 * off_major;
            off_major = (off_major - 1) & 8'hff;
        end
        steps_remaining = (steps_remaining - 1) & 8'hff;
        if (steps_remaining == 0)
        begin
            if (off_major == off_minor)
                push_octants(off_major, off_minor);
            if (ring_r <= 1)
            begin
                w = expected_pixels[expected_pixels.size() - 1];
                w.last_point = 1'b1;
                expected_pixels[expected_pixels.size() - 1] = w;
                disc_busy = 1'b0;
                arm_ring(0);
            end
            else
                arm_ring(ring_r - 1);
        end
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        disc_word_t dw;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                dw.op = op_t'(operation);
                dw.cx = center_x;
                dw.cy = center_y;
                compute_disc_points(dw);
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    dw = pending_words.pop_front();
                    operation <= dw.op;
                    center_x <= dw.cx;
                    center_y <= dw.cy;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        pixel_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                pixels_checked++;
                if (last_point === 1'b1)
                    discs_closed++;
                if (expected_pixels.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("unexpected pixel word x=%0d y=%0d r=%0d last=%b",
                                 pixel_x, pixel_y, ring_radius, last_point);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.pixel_x || pixel_y !== want.pixel_y ||
                        ring_radius !== want.ring_radius ||
                        last_point !== want.last_point)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("pixel mismatch exp x=%0d y=%0d r=%0d last=%b got x=%0d y=%0d r=%0d last=%b",
                                     want.pixel_x, want.pixel_y, want.ring_radius,
                                     want.last_point, pixel_x, pixel_y, ring_radius,
                                     last_point);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_word(input op_t op, input int cx, input int cy);
        disc_word_t dw;
        dw.op = op;
        dw.cx = cx[CENTRE_IN_BITS-1:0];
        dw.cy = cy[CENTRE_IN_BITS-1:0];
        pending_words.insert(pending_words.size(), dw);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(7))
            0: return 0;
            1: return (1 << CENTRE_IN_BITS) - 1;
            default: return $urandom_range((1 << CENTRE_IN_BITS) - 1);
        endcase
    endfunction

    task automatic wait_for_drain();
        while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_radius(input int v);
        wait_for_drain();
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v[RAD_BITS-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
        radius_setting = v[RAD_BITS-1:0];
    endtask

    // returns the number of words queued
    task automatic queue_disc(input int r, input bit cut_short, output int added);
        int n;
        n = r * (r + 1) / 2;
        if (r == 0)
            n = $urandom_range(1, 3);
        else if (r > 16)
            n = $urandom_range(1, 12);
        else if (cut_short)
            n = $urandom_range(n - 1);
        add_word(OP_START, pick_coord(), pick_coord());
        repeat (n) add_word(OP_ADVANCE, pick_coord(), pick_coord());
        added = n + 1;
    endtask

    initial
    begin
        int mode;
        int mode_items;
        int r;
        int added;
        int discs;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset radius, idle advance, starts at the corners, restart while busy
        send_idle_pct = 17;
        recv_stall_pct = 55;
        add_word(OP_ADVANCE, 1023, 0);
        add_word(OP_START, 0, 0);
        repeat (3) add_word(OP_ADVANCE, 0, 1023);
        add_word(OP_START, 1023, 1023);
        repeat (2) add_word(OP_ADVANCE, 0, 0);
        write_max_radius(1);
        add_word(OP_START, 512, 300);
        add_word(OP_ADVANCE, 0, 0);
        add_word(OP_ADVANCE, 0, 0);
        write_max_radius(0);
        add_word(OP_START, 5, 5);
        add_word(OP_ADVANCE, 5, 5);
        write_max_radius(255);
        add_word(OP_START, 0, 1023);
        repeat (2) add_word(OP_ADVANCE, 1023, 1023);
        write_max_radius(2);
        add_word(OP_START, 100, 200);
        repeat (4) add_word(OP_ADVANCE, 341, 682);

        // random: three idle/stall mixes
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 17;
                    recv_stall_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_stall_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            mode_items = 0;
            while (mode_items < MODE_ITEMS)
            begin
                case ($urandom_range(11))
                    0: r = 0;
                    1: r = 255;
                    2: r = $urandom_range(7, 10);
                    default: r = $urandom_range(1, 6);
                endcase
                write_max_radius(r);
                discs = $urandom_range(1, 3);
                repeat (discs)
                begin
                    queue_disc(r, ($urandom_range(3) == 0), added);
                    mode_items += added;
                end
                // noise
                repeat ($urandom_range(3))
                begin
                    add_word(op_t'($urandom_range(1)), pick_coord(), pick_coord());
                    mode_items++;
                end
            end
        end

        wait_for_drain();
        $display("summary: %0d input words, %0d pixel words checked, %0d discs completed",
                 words_accepted, pixels_checked, discs_closed);
        $display("radius settings 0, 1, 255 and random small rings under three stall mixes");
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d pixel words outstanding",
                     mismatch_count, expected_pixels.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d pixel words outstanding", expected_pixels.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
